// ===== rtl/core/rpa_pkg.sv =====
// Shared types, constants and helpers for the signal-strength percentage block.
// No dependencies; every module in rtl/core refers here by scoped names.
package rpa_pkg;

    localparam int RAW_W   = 8;
    localparam int LVL_W   = 9;
    localparam int PCT_W   = 7;
    localparam int NUM_W   = 16;
    localparam int DEN_W   = 9;
    localparam int CNT_W   = 4;
    localparam int MODE_W  = 2;
    localparam int ADDR_W  = 2;

    localparam logic signed [LVL_W-1:0] DBM_OFFSET = 9'sd70;
    localparam logic signed [LVL_W:0]   SPAN_STEP  = 10'sd20;
    localparam logic signed [LVL_W:0]   LVL_MAX    = 10'sd255;
    localparam logic [PCT_W-1:0]        PCT_FULL   = 7'd100;

    localparam logic signed [LVL_W-1:0] LOW_START_RST  = -9'sd100;
    localparam logic signed [LVL_W-1:0] HIGH_START_RST = -9'sd30;

    // register indexes
    localparam logic [ADDR_W-1:0] REG_CALIB_MODE = 2'd0;
    localparam logic [ADDR_W-1:0] REG_LOW_START  = 2'd1;
    localparam logic [ADDR_W-1:0] REG_HIGH_START = 2'd2;

    // calibration modes
    localparam logic [MODE_W-1:0] MODE_NONE       = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TRACK_LOW  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TRACK_HIGH = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRACK,
        ST_SETUP,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  dividend;
        logic [DEN_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [NUM_W-1:0]  quotient;
    } div_rsp_t;

    typedef struct packed {
        logic                     track;
        logic signed [LVL_W-1:0]  dbm;
    } track_req_t;

    // Sign-extend, halve toward zero, subtract the dBm offset.
    function automatic logic signed [LVL_W-1:0] raw_to_dbm(input logic [RAW_W-1:0] raw);
        logic signed [LVL_W-1:0] ext;
        logic signed [LVL_W-1:0] half;
        begin
            ext  = signed'({raw[RAW_W-1], raw}) + signed'({{(LVL_W-1){1'b0}}, raw[RAW_W-1]});
            half = ext >>> 1;
            return half - DBM_OFFSET;
        end
    endfunction

endpackage

// ===== rtl/core/rpa_divider.sv =====
// Restoring serial divider: one quotient bit per cycle, unsigned operands.
// Depends on rpa_pkg for widths and the request/response structs.
module rpa_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  rpa_pkg::div_req_t req,
    output rpa_pkg::div_rsp_t rsp
);

    logic [rpa_pkg::DEN_W-1:0] rem_reg,  rem_next;
    logic [rpa_pkg::NUM_W-1:0] quo_reg,  quo_next;
    logic [rpa_pkg::DEN_W-1:0] dsr_reg,  dsr_next;
    logic [rpa_pkg::CNT_W-1:0] cnt_reg,  cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;

    logic [rpa_pkg::DEN_W:0]   shifted;
    logic [rpa_pkg::DEN_W+1:0] trial;

    always_comb begin
        shifted   = {rem_reg, quo_reg[rpa_pkg::NUM_W-1]};
        trial     = {1'b0, shifted} - {2'b00, dsr_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
            cnt_next  = '1;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // keep the difference only when it did not borrow
            if (!trial[rpa_pkg::DEN_W+1]) begin
                rem_next = trial[rpa_pkg::DEN_W-1:0];
            end else begin
                rem_next = shifted[rpa_pkg::DEN_W-1:0];
            end
            quo_next = {quo_reg[rpa_pkg::NUM_W-2:0], ~trial[rpa_pkg::DEN_W+1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== rtl/core/rpa_levels.sv =====
// Configuration registers and the tracked lower/upper scale levels.
// Depends on rpa_pkg for mode and register codes and the tracking struct.
module rpa_levels (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [rpa_pkg::ADDR_W-1:0]          cfg_addr,
    input  logic [rpa_pkg::LVL_W-1:0]           cfg_wdata,
    input  rpa_pkg::track_req_t                 trk,
    output logic signed [rpa_pkg::LVL_W-1:0]    low_level,
    output logic signed [rpa_pkg::LVL_W-1:0]    high_level
);

    logic [rpa_pkg::MODE_W-1:0]        mode_reg,   mode_next;
    logic signed [rpa_pkg::LVL_W-1:0]  lstart_reg, lstart_next;
    logic signed [rpa_pkg::LVL_W-1:0]  hstart_reg, hstart_next;
    logic signed [rpa_pkg::LVL_W-1:0]  low_reg,    low_next;
    logic signed [rpa_pkg::LVL_W-1:0]  high_reg,   high_next;
    logic                              seeded_reg, seeded_next;

    logic                              reload;
    logic signed [rpa_pkg::LVL_W:0]    span_top;
    logic signed [rpa_pkg::LVL_W:0]    avg_sum;
    logic signed [rpa_pkg::LVL_W:0]    avg_half;

    always_comb begin
        mode_next   = mode_reg;
        lstart_next = lstart_reg;
        hstart_next = hstart_reg;
        reload      = 1'b0;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                rpa_pkg::REG_CALIB_MODE: begin
                    mode_next = cfg_wdata[rpa_pkg::MODE_W-1:0];
                    reload    = 1'b1;
                end
                rpa_pkg::REG_LOW_START: begin
                    lstart_next = signed'(cfg_wdata);
                    reload      = 1'b1;
                end
                rpa_pkg::REG_HIGH_START: begin
                    hstart_next = signed'(cfg_wdata);
                    reload      = 1'b1;
                end
                default: reload = 1'b0;
            endcase
        end

        span_top = {lstart_next[rpa_pkg::LVL_W-1], lstart_next} + rpa_pkg::SPAN_STEP;
        avg_sum  = {low_reg[rpa_pkg::LVL_W-1], low_reg}
                 + {trk.dbm[rpa_pkg::LVL_W-1], trk.dbm};
        avg_half = (avg_sum + signed'({{rpa_pkg::LVL_W{1'b0}}, avg_sum[rpa_pkg::LVL_W]})) >>> 1;

        low_next    = low_reg;
        high_next   = high_reg;
        seeded_next = seeded_reg;
        if (reload) begin
            low_next    = lstart_next;
            high_next   = hstart_next;
            seeded_next = (mode_next != rpa_pkg::MODE_TRACK_LOW);
            if (mode_next == rpa_pkg::MODE_TRACK_HIGH) begin
                // saturate the seeded upper level
                if (span_top > rpa_pkg::LVL_MAX) begin
                    high_next = rpa_pkg::LVL_MAX[rpa_pkg::LVL_W-1:0];
                end else begin
                    high_next = span_top[rpa_pkg::LVL_W-1:0];
                end
            end
        end else if (trk.track) begin
            if (mode_reg == rpa_pkg::MODE_TRACK_LOW) begin
                if (!seeded_reg) begin
                    low_next    = trk.dbm;
                    seeded_next = 1'b1;
                end else if (low_reg > trk.dbm) begin
                    low_next = avg_half[rpa_pkg::LVL_W-1:0];
                end
            end else if (mode_reg == rpa_pkg::MODE_TRACK_HIGH) begin
                if (high_reg < trk.dbm) begin
                    high_next = trk.dbm;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= rpa_pkg::MODE_NONE;
            lstart_reg <= rpa_pkg::LOW_START_RST;
            hstart_reg <= rpa_pkg::HIGH_START_RST;
            low_reg    <= rpa_pkg::LOW_START_RST;
            high_reg   <= rpa_pkg::HIGH_START_RST;
            seeded_reg <= 1'b1;
        end else begin
            mode_reg   <= mode_next;
            lstart_reg <= lstart_next;
            hstart_reg <= hstart_next;
            low_reg    <= low_next;
            high_reg   <= high_next;
            seeded_reg <= seeded_next;
        end
    end

    assign low_level  = low_reg;
    assign high_level = high_reg;

endmodule

// ===== rtl/core/rssi_percent_autocal_unit.sv =====
// Top level: raw strength byte to dBm and a 0..100 scale percentage.
// Depends on rpa_pkg, rpa_levels and rpa_divider.
//
//   channel   direction  ports                  payload
//   input     slave      s_tvalid/s_tready      s_tdata[7:0] raw_strength
//   result    master     m_tvalid/m_tready      m_tdata level/percent/range_empty
//   config    write      cfg_wr_en              cfg_addr, cfg_wdata
//
// An item runs through tracking the levels, setting up the divide, 16 steps of
// the serial divider plus its done strobe, and loading the result register; the
// next transfer is taken only once the block is back in idle, so a new item is
// not taken before the last one has been loaded.
// Reset (aresetn, synchronous) restores the default registers and levels.
// A finished result waits in the output register; a new item may be taken
// meanwhile, and its result stalls in the last state until that one leaves.
module rssi_percent_autocal_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] raw_strength
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,   // [8:0] level_dbm, [15:9] percent,
                                                     // [16] range_empty, [23:17] zero
    input  logic                          cfg_wr_en,
    input  logic [rpa_pkg::ADDR_W-1:0]    cfg_addr,
    input  logic [rpa_pkg::LVL_W-1:0]     cfg_wdata
);

    rpa_pkg::state_t state_reg, state_next;

    logic signed [rpa_pkg::LVL_W-1:0] dbm_reg,   dbm_next;
    logic                             neg_reg,   neg_next;
    logic                             empty_reg, empty_next;
    logic                             mval_reg,  mval_next;
    logic signed [rpa_pkg::LVL_W-1:0] mdbm_reg,  mdbm_next;
    logic [rpa_pkg::PCT_W-1:0]        mpct_reg,  mpct_next;
    logic                             memp_reg,  memp_next;

    logic signed [rpa_pkg::LVL_W-1:0] low_level;
    logic signed [rpa_pkg::LVL_W-1:0] high_level;
    rpa_pkg::track_req_t              trk;
    rpa_pkg::div_req_t                div_req;
    rpa_pkg::div_rsp_t                div_rsp;

    logic signed [rpa_pkg::LVL_W:0]   diff;
    logic signed [rpa_pkg::LVL_W:0]   span;
    logic [rpa_pkg::LVL_W:0]          diff_abs;
    logic [rpa_pkg::LVL_W:0]          span_abs;
    logic [rpa_pkg::NUM_W-1:0]        diff_ext;
    logic [rpa_pkg::PCT_W-1:0]        pct_clamped;
    logic                             accept;

    rpa_levels u_levels (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .trk        (trk),
        .low_level  (low_level),
        .high_level (high_level)
    );

    rpa_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Numerator and divisor from the freshly tracked levels.
    always_comb begin
        diff     = {dbm_reg[rpa_pkg::LVL_W-1], dbm_reg} - {low_level[rpa_pkg::LVL_W-1], low_level};
        span     = {high_level[rpa_pkg::LVL_W-1], high_level}
                 - {low_level[rpa_pkg::LVL_W-1], low_level};
        diff_abs = diff[rpa_pkg::LVL_W] ? 10'(-diff) : 10'(diff);
        span_abs = span[rpa_pkg::LVL_W] ? 10'(-span) : 10'(span);
        diff_ext = {{(rpa_pkg::NUM_W-rpa_pkg::LVL_W-1){1'b0}}, diff_abs};
        // clamp the quotient to full scale
        if (div_rsp.quotient > {{(rpa_pkg::NUM_W-rpa_pkg::PCT_W){1'b0}}, rpa_pkg::PCT_FULL}) begin
            pct_clamped = rpa_pkg::PCT_FULL;
        end else begin
            pct_clamped = div_rsp.quotient[rpa_pkg::PCT_W-1:0];
        end
    end

    assign accept = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        dbm_next   = dbm_reg;
        neg_next   = neg_reg;
        empty_next = empty_reg;
        mval_next  = mval_reg;
        mdbm_next  = mdbm_reg;
        mpct_next  = mpct_reg;
        memp_next  = memp_reg;
        s_tready   = 1'b0;
        trk.track  = 1'b0;
        trk.dbm    = dbm_reg;
        div_req.start    = 1'b0;
        // x*100 as shifts: 64x + 32x + 4x
        div_req.dividend = (diff_ext << 6) + (diff_ext << 5) + (diff_ext << 2);
        div_req.divisor  = span_abs[rpa_pkg::DEN_W-1:0];

        // drop the held result once taken
        if (mval_reg && m_tready) begin
            mval_next = 1'b0;
        end

        unique case (state_reg)
            rpa_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (accept) begin
                    dbm_next   = rpa_pkg::raw_to_dbm(s_tdata);
                    state_next = rpa_pkg::ST_TRACK;
                end
            end
            rpa_pkg::ST_TRACK: begin
                trk.track  = 1'b1;
                state_next = rpa_pkg::ST_SETUP;
            end
            rpa_pkg::ST_SETUP: begin
                div_req.start = 1'b1;
                empty_next    = (span == '0);
                // opposite signs truncate to zero or below: clamp to zero
                neg_next      = diff[rpa_pkg::LVL_W] ^ span[rpa_pkg::LVL_W];
                state_next    = rpa_pkg::ST_DIV;
            end
            rpa_pkg::ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = rpa_pkg::ST_DONE;
                end
            end
            rpa_pkg::ST_DONE: begin
                if (!mval_reg || m_tready) begin
                    mval_next  = 1'b1;
                    mdbm_next  = dbm_reg;
                    mpct_next  = (empty_reg || neg_reg) ? '0 : pct_clamped;
                    memp_next  = empty_reg;
                    state_next = rpa_pkg::ST_IDLE;
                end
            end
            default: state_next = rpa_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        dbm_reg   <= dbm_next;
        neg_reg   <= neg_next;
        empty_reg <= empty_next;
        mdbm_reg  <= mdbm_next;
        mpct_reg  <= mpct_next;
        memp_reg  <= memp_next;
        if (!aresetn) begin
            state_reg <= rpa_pkg::ST_IDLE;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            mval_reg  <= mval_next;
        end
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = {7'd0, memp_reg, mpct_reg, mdbm_reg};

`ifndef SYNTHESIS
    a_accept_to_track: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == rpa_pkg::ST_TRACK)
        else $error("accepted item did not enter level tracking");

    a_pct_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mval_reg |-> mpct_reg <= rpa_pkg::PCT_FULL)
        else $error("percent above full scale");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        mval_reg && memp_reg |-> mpct_reg == '0)
        else $error("empty range with nonzero percent");

    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> state_reg == rpa_pkg::ST_DIV)
        else $error("divider finished outside the divide state");

    a_start_from_setup: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == rpa_pkg::ST_SETUP |=> state_reg == rpa_pkg::ST_DIV)
        else $error("setup did not hand over to the divider");
`endif

endmodule
